FILE: hw/rtl/omd_pkg.sv
// Shared types and constants for the outlier mask and dilation block.
package omd_pkg;

    localparam int unsigned DIM_W      = 10;   // width and height registers
    localparam int unsigned IDX_W      = 20;   // linear pixel index within a frame
    localparam int unsigned PIX_W      = 16;
    localparam int unsigned LIM_W      = 32;
    localparam int unsigned Q_W        = 34;   // signed normalised value
    localparam int unsigned DIM_MIN    = 3;
    localparam int unsigned HEIGHT_CAP = 512;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned NB_COUNT   = 4;    // forward neighbours of a pixel

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_BIAS   = 3'd2,
        CFG_SKY    = 3'd3,
        CFG_MEAN   = 3'd4,
        CFG_BAD    = 3'd5,
        CFG_POOR   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_BAD    = 2'd0,
        CLS_GOOD   = 2'd1,
        CLS_POOR   = 2'd2,
        CLS_FORCED = 2'd3   // poor pixel already zeroed by a finalised neighbour
    } t_cls;

    typedef struct packed {
        logic [PIX_W-1:0]        bias;
        logic [PIX_W-1:0]        sky;
        logic [PIX_W-1:0]        mean;
        logic signed [LIM_W-1:0] bad;
        logic signed [LIM_W-1:0] poor;
    } t_levels;

    // command from the classifier to the mask stage
    typedef struct packed {
        logic                wr;     // store a class in the window
        t_cls                cls;
        logic                fin;    // finalise the oldest pending pixel
        logic [NB_COUNT-1:0] nb_ok;  // neighbour +1, +w-1, +w, +w+1 already received
        logic                fend;
    } t_cmd;

    typedef enum logic [2:0] {
        FE_IDLE,
        FE_MUL,
        FE_ABS,
        FE_DIV,
        FE_CLS
    } t_fe_state;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_WRITE,
        BE_READ,
        BE_EVAL,
        BE_FORCE,
        BE_OUT
    } t_be_state;

endpackage

FILE: hw/rtl/outlier_mask_dilate_top.sv
// Outlier mask with one-step dilation: top level, configuration registers and wiring.
// A pixel transfer is classified in steps: one multiply, one absolute-value step,
// a 32-step restoring divider (one quotient bit per cycle) and the class decision;
// the classifier takes the next item only once that decision is made. Each result
// then passes the mask stage (queue pop, window write, class RAM reads of the pixel
// and its four neighbours, evaluation, up to four forcing writes, output load),
// overlapped with the next classification through a four-entry command queue.
// Results trail their pixels by width+1 pixels; flush transfers (tuser high) drain
// the last ones of a frame. The input is held off in the cycle after any
// configuration write.
module outlier_mask_dilate_top #(
    parameter int unsigned MAX_WIDTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] pixel_value, [31:16] flat_value
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] mask_value, [7:1] zero
    output logic        m_axis_tlast,   // frame_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import omd_pkg::*;

    localparam int unsigned WCAP = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;

    logic [DIM_W-1:0] r_width, r_height, eff_w, eff_h;
    logic [IDX_W-1:0] r_total;
    t_levels          r_lv;
    logic             r_settle;
    logic             cfg_fire, restart;

    logic   q_push, q_full, q_pop, q_empty, fe_ready, o_mask;
    t_cmd   q_in, q_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_fire && (i_cfg_index inside {CFG_WIDTH, CFG_HEIGHT});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= DIM_W'(64);
            r_height  <= DIM_W'(64);
            r_lv.bias <= '0;
            r_lv.sky  <= PIX_W'(1000);
            r_lv.mean <= PIX_W'(10000);
            r_lv.bad  <= LIM_W'(100);
            r_lv.poor <= LIM_W'(60);
        end else if (cfg_fire) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width   <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height  <= i_cfg_data[DIM_W-1:0];
                CFG_BIAS:   r_lv.bias <= i_cfg_data[PIX_W-1:0];
                CFG_SKY:    r_lv.sky  <= i_cfg_data[PIX_W-1:0];
                CFG_MEAN:   r_lv.mean <= i_cfg_data[PIX_W-1:0];
                CFG_BAD:    r_lv.bad  <= $signed(i_cfg_data);
                CFG_POOR:   r_lv.poor <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // the frame size product is registered behind the size registers
    always_ff @(posedge i_clk) begin
        r_settle <= cfg_fire;
        r_total  <= IDX_W'(eff_w * eff_h);
    end

    always_comb begin
        eff_w = r_width;
        if (r_width < DIM_W'(DIM_MIN)) eff_w = DIM_W'(DIM_MIN);
        else if (r_width > DIM_W'(WCAP)) eff_w = DIM_W'(WCAP);
        eff_h = r_height;
        if (r_height < DIM_W'(DIM_MIN)) eff_h = DIM_W'(DIM_MIN);
        else if (r_height > DIM_W'(HEIGHT_CAP)) eff_h = DIM_W'(HEIGHT_CAP);
    end

    omd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_hold    (r_settle),
        .i_eff_w   (eff_w),
        .i_eff_h   (eff_h),
        .i_total   (r_total),
        .i_lv      (r_lv),
        .i_valid   (s_axis_tvalid),
        .o_ready   (fe_ready),
        .i_kind    (s_axis_tuser),
        .i_pix     (s_axis_tdata[15:0]),
        .i_flat    (s_axis_tdata[31:16]),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_cmd     (q_in)
    );

    omd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty)
    );

    omd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_eff_w   (eff_w),
        .i_q_empty (q_empty),
        .i_cmd     (q_out),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_mask    (o_mask),
        .o_last    (m_axis_tlast)
    );

    assign s_axis_tready = fe_ready;
    assign m_axis_tdata  = {7'd0, o_mask};

endmodule

FILE: hw/rtl/omd_ram.sv
// Generic simple dual-port RAM with registered read.
module omd_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 514
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/omd_queue.sv
// Short command queue between the classifier and the mask stage.
module omd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  omd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output omd_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import omd_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PW    = $clog2(DEPTH);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_slot[r_rp];

endmodule

FILE: hw/rtl/omd_front.sv
// Classifier: frame position tracking, normalisation divider and class decision.
module omd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic                          i_hold,
    input  logic [omd_pkg::DIM_W-1:0]     i_eff_w,
    input  logic [omd_pkg::DIM_W-1:0]     i_eff_h,
    input  logic [omd_pkg::IDX_W-1:0]     i_total,
    input  omd_pkg::t_levels              i_lv,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [omd_pkg::PIX_W-1:0]     i_pix,
    input  logic [omd_pkg::PIX_W-1:0]     i_flat,
    input  logic                          i_q_full,
    output logic                          o_push,
    output omd_pkg::t_cmd                 o_cmd
);
    import omd_pkg::*;

    localparam int unsigned PROD_W = 33;
    localparam int unsigned QUO_W  = 32;
    localparam int unsigned CNT_W  = $clog2(QUO_W);

    t_fe_state r_state, n_state;

    logic [DIM_W-1:0] r_col, n_col, r_row, n_row;
    logic [IDX_W-1:0] r_rcv, n_rcv, r_oidx, n_oidx;

    logic [PIX_W-1:0]         r_pix, r_flat;
    logic                     r_interior, r_fin, r_fend, r_gate, r_neg;
    logic [NB_COUNT-1:0]      r_nb_ok;
    logic signed [PROD_W-1:0] r_prod;
    logic [QUO_W-1:0]         r_quo;
    logic [PIX_W-1:0]         r_rem;
    logic [CNT_W-1:0]         r_cnt;
    t_cls                     cls_q;

    logic                accept, frame_full, flush_go, pixel_go, fin_now, fend_now;
    logic [IDX_W-1:0]    rcv_after, w_ext, total_m1;
    logic [IDX_W-1:0]    nb_off [NB_COUNT];
    logic [NB_COUNT-1:0] nb_ok_now;
    logic                interior_now;

    assign accept     = i_valid && o_ready;
    assign w_ext      = IDX_W'(i_eff_w);
    assign total_m1   = i_total - 1'b1;
    assign frame_full = (r_rcv >= i_total);
    assign flush_go   = accept && i_kind && frame_full && (r_oidx < i_total);
    assign pixel_go   = accept && !i_kind && !frame_full;
    assign fin_now    = flush_go || (pixel_go && (r_rcv >= w_ext + 1'b1));
    assign fend_now   = (r_oidx == total_m1);
    assign rcv_after  = i_kind ? r_rcv : r_rcv + 1'b1;

    assign nb_off[0] = IDX_W'(1);
    assign nb_off[1] = w_ext - 1'b1;
    assign nb_off[2] = w_ext;
    assign nb_off[3] = w_ext + 1'b1;

    always_comb begin
        for (int j = 0; j < NB_COUNT; j++) begin
            nb_ok_now[j] = (r_oidx + nb_off[j]) < rcv_after;
        end
    end

    assign interior_now = (r_col != '0) && (r_col < i_eff_w - 1'b1) &&
                          (r_row != '0) && (r_row < i_eff_h - 1'b1);

    // frame position counters move at the transfer itself
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_rcv  = r_rcv;
        n_oidx = r_oidx;
        if (pixel_go) begin
            n_rcv = r_rcv + 1'b1;
            if (r_col + 1'b1 >= i_eff_w) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        if (fin_now) begin
            n_oidx = r_oidx + 1'b1;
        end
        if (i_restart || (fin_now && fend_now)) begin
            n_col  = '0;
            n_row  = '0;
            n_rcv  = '0;
            n_oidx = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FE_IDLE: if (pixel_go) n_state = FE_MUL;
            FE_MUL:  n_state = FE_ABS;
            FE_ABS:  n_state = FE_DIV;
            FE_DIV:  if (r_cnt == CNT_W'(QUO_W - 1)) n_state = FE_CLS;
            FE_CLS:  n_state = FE_IDLE;
            default: n_state = FE_IDLE;
        endcase
    end

    // class of the finished quotient
    logic signed [Q_W-1:0] quo_s, q_val;
    always_comb begin
        quo_s = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
        q_val = r_gate ? quo_s - $signed({{(Q_W-PIX_W){1'b0}}, i_lv.sky}) : '0;
        if (q_val > Q_W'(i_lv.bad)) begin
            cls_q = CLS_BAD;
        end else if (q_val > Q_W'(i_lv.poor) && r_interior) begin
            cls_q = CLS_POOR;
        end else begin
            cls_q = CLS_GOOD;
        end
    end

    always_comb begin
        o_ready = (r_state == FE_IDLE) && !i_q_full && !i_hold;
        o_push  = 1'b0;
        o_cmd   = '{wr: 1'b0, cls: CLS_GOOD, fin: 1'b0, nb_ok: '0, fend: 1'b0};
        case (r_state)
            FE_IDLE: begin
                if (flush_go) begin
                    o_push = 1'b1;
                    o_cmd  = '{wr: 1'b0, cls: CLS_GOOD, fin: 1'b1, nb_ok: nb_ok_now,
                               fend: fend_now};
                end
            end
            FE_CLS: begin
                o_push = 1'b1;
                o_cmd  = '{wr: 1'b1, cls: cls_q, fin: r_fin, nb_ok: r_nb_ok, fend: r_fend};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_rcv   <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_rcv   <= n_rcv;
            r_oidx  <= n_oidx;
        end
    end

    logic [PIX_W:0] div_try;
    assign div_try = {r_rem, r_quo[QUO_W-1]};

    always_ff @(posedge i_clk) begin
        case (r_state)
            FE_IDLE: begin
                if (pixel_go) begin
                    r_pix      <= i_pix;
                    r_flat     <= i_flat;
                    r_gate     <= (i_flat > i_lv.sky);
                    r_interior <= interior_now;
                    r_fin      <= fin_now;
                    r_fend     <= fend_now;
                    r_nb_ok    <= nb_ok_now;
                end
            end
            FE_MUL: begin
                r_prod <= PROD_W'(($signed({1'b0, r_pix}) - $signed({1'b0, i_lv.bias}))
                                  * $signed({1'b0, i_lv.mean}));
            end
            FE_ABS: begin
                r_neg <= r_prod[PROD_W-1];
                r_quo <= r_prod[PROD_W-1] ? QUO_W'(-r_prod) : QUO_W'(r_prod);
                r_rem <= '0;
                r_cnt <= '0;
            end
            FE_DIV: begin
                // one restoring step per cycle
                if (div_try >= {1'b0, r_flat}) begin
                    r_rem <= PIX_W'(div_try - {1'b0, r_flat});
                    r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= PIX_W'(div_try);
                    r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/omd_back.sv
// Mask stage: class window, neighbour check, forcing of poor neighbours, output register.
module omd_back #(
    parameter int unsigned MAX_WIDTH = 512
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_restart,
    input  logic [omd_pkg::DIM_W-1:0] i_eff_w,
    input  logic                      i_q_empty,
    input  omd_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_mask,
    output logic                      o_last
);
    import omd_pkg::*;

    localparam int unsigned DEPTH = MAX_WIDTH + 2;
    localparam int unsigned SW    = $clog2(DEPTH);
    localparam int unsigned SUMW  = ((SW > DIM_W + 1) ? SW : DIM_W + 1) + 1;
    localparam int unsigned RD_N  = NB_COUNT + 1;
    localparam int unsigned KW    = $clog2(RD_N + 1);

    t_be_state r_state, n_state;

    t_cmd            r_cmd;
    logic [SW-1:0]   r_wr_slot, r_p_slot;
    logic [KW-1:0]   r_k;
    logic [1:0]      r_nb [RD_N];
    logic            r_res;
    logic            r_ovalid, r_omask, r_olast;

    logic            ram_we, ram_re;
    logic [SW-1:0]   ram_waddr, ram_raddr;
    logic [1:0]      ram_wdata, ram_rdata;
    logic            out_free, res_now;

    // offset of window entry k from the pixel being finalised
    function automatic logic [SUMW-1:0] off_of(input logic [KW-1:0] k,
                                               input logic [DIM_W-1:0] w);
        logic [SUMW-1:0] o;
        case (k)
            KW'(0):  o = '0;
            KW'(1):  o = SUMW'(1);
            KW'(2):  o = SUMW'(w) - 1'b1;
            KW'(3):  o = SUMW'(w);
            default: o = SUMW'(w) + 1'b1;
        endcase
        return o;
    endfunction

    function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] base,
                                               input logic [SUMW-1:0] off);
        logic [SUMW-1:0] s;
        s = SUMW'(base) + off;
        if (s >= SUMW'(DEPTH)) begin
            s = s - SUMW'(DEPTH);
        end
        return SW'(s);
    endfunction

    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        res_now = 1'b0;
        case (t_cls'(r_nb[0]))
            CLS_GOOD: res_now = 1'b1;
            CLS_POOR: begin
                res_now = 1'b1;
                for (int j = 0; j < NB_COUNT; j++) begin
                    if (r_cmd.nb_ok[j] && t_cls'(r_nb[j+1]) == CLS_BAD) begin
                        res_now = 1'b0;
                    end
                end
            end
            default: res_now = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BE_IDLE:  if (!i_q_empty) n_state = i_cmd.wr ? BE_WRITE : BE_READ;
            BE_WRITE: n_state = r_cmd.fin ? BE_READ : BE_IDLE;
            BE_READ:  if (r_k == KW'(RD_N)) n_state = BE_EVAL;
            BE_EVAL:  n_state = BE_FORCE;
            BE_FORCE: if (r_k == KW'(NB_COUNT - 1)) n_state = BE_OUT;
            BE_OUT:   if (out_free) n_state = BE_IDLE;
            default:  n_state = BE_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_wr_slot;
        ram_wdata = r_cmd.cls;
        ram_re    = 1'b0;
        ram_raddr = slot_add(r_p_slot, off_of(r_k, i_eff_w));
        case (r_state)
            BE_IDLE:  o_pop = !i_q_empty;
            BE_WRITE: ram_we = 1'b1;
            BE_READ:  ram_re = (r_k < KW'(RD_N));
            BE_FORCE: begin
                ram_waddr = slot_add(r_p_slot, off_of(r_k + 1'b1, i_eff_w));
                ram_wdata = CLS_FORCED;
                ram_we    = !r_res && r_cmd.nb_ok[r_k[$clog2(NB_COUNT)-1:0]] &&
                            t_cls'(r_nb[r_k + 1'b1]) == CLS_POOR;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BE_IDLE;
            r_wr_slot <= '0;
            r_p_slot  <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BE_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_restart) begin
                r_wr_slot <= '0;
                r_p_slot  <= '0;
            end else if (r_state == BE_OUT && out_free) begin
                if (r_cmd.fend) begin
                    r_wr_slot <= '0;
                    r_p_slot  <= '0;
                end else begin
                    r_p_slot <= (r_p_slot == SW'(DEPTH - 1)) ? '0 : r_p_slot + 1'b1;
                end
            end else if (r_state == BE_WRITE) begin
                r_wr_slot <= (r_wr_slot == SW'(DEPTH - 1)) ? '0 : r_wr_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BE_IDLE: begin
                r_cmd <= i_cmd;
                r_k   <= '0;
            end
            BE_READ: begin
                // read data is registered, so it arrives in the cycle after its address
                if (r_k != '0) begin
                    r_nb[r_k - 1'b1] <= ram_rdata;
                end
                r_k <= (r_k == KW'(RD_N)) ? '0 : r_k + 1'b1;
            end
            BE_EVAL:  r_res <= res_now;
            BE_FORCE: r_k <= r_k + 1'b1;
            BE_OUT: begin
                if (out_free) begin
                    r_omask <= r_res;
                    r_olast <= r_cmd.fend;
                end
            end
            default: ;
        endcase
    end

    omd_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_win (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign o_valid = r_ovalid;
    assign o_mask  = r_omask;
    assign o_last  = r_olast;

endmodule

FILE: hw/rtl/omd_checker.sv
// Port-level checks for the outlier mask block, bound to the top level.
module omd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [31:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown straight after reset");

    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !s_axis_tready)
        else $error("input taken in the cycle after a register write");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("padding bits of result not zero");

endmodule

bind outlier_mask_dilate_top omd_checker u_omd_checker (.*);
